// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, codes and constants of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_ORDER_DEF = 8;
  localparam int SIZE_W        = 24;
  localparam int LOG2_W        = 5;
  localparam int CFG_IDX_W     = 1;

  localparam logic [LOG2_W-1:0] MIN_UNIT_RST = 5'd8;
  localparam logic [LOG2_W-1:0] ALIGN_RST    = 5'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_UNIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN    = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_PROBE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_TOO_LARGE = 2'd1,
    STS_NO_SPACE  = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [SIZE_W-1:0]  size_bytes;
    logic [SIZE_W-1:0]  free_offset_bytes;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [SIZE_W-1:0]  alloc_offset_bytes;
    logic               fits;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UNITS,
    S_ORDER,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SPLIT,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_wr;
    logic    load;
    logic    units_calc;
    logic    ord_step;
    logic    srch_start;
    logic    free_start;
    logic    rd_cur;
    logic    rd_buddy;
    logic    blk_next;
    logic    ord_next;
    logic    wr_cur0;
    logic    split_step;
    logic    merge_step;
    logic    wr_cur1;
    logic    set_status;
    status_t status_code;
    logic    set_fits;
    logic    set_off;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    clr_last;
    opcode_t op;
    logic    ord_done;
    logic    ord_over;
    logic    free_bad;
    logic    mark;
    logic    blk_last;
    logic    cur_top;
    logic    at_req;
  } dp_sts_t;

endpackage

// File: rtl/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// buddy allocator over 2^MAX_ORDER minimum units with a free mark per block
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its 2^(MAX_ORDER+1)-1 free
// marks, one per cycle, holding busy high; afterwards only the whole region is
// free. Items are taken one at a time when start is high and busy is low, and
// each gives one result on out_item for a single cycle with out_valid; the
// receiver cannot stall, so the result must be captured on that cycle. An item
// is loaded, converted to units and stepped through up to MAX_ORDER+1 order
// steps; allocate and probe then read and check free marks in the mark memory,
// lowest block first, up to 2^(MAX_ORDER+1)-1 marks, and a successful allocate
// takes one split step per level and then sets its offset; a free reads the
// buddy mark for each merged level and then sets its own mark. The mark memory
// has a single registered read port, which sets the search time. Configuration
// writes are taken only while the block is idle and start is low.
module buddy_block_allocator_core import bba_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LOG2_W-1:0]    cfg_wdata
);

  cmd_t    cmd;
  dp_sts_t sts;

  // configuration only between transactions
  assign cfg_ready = !busy && !start;

  // sequencer
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath and mark store
  bba_dpath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

// File: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer for clearing, order search, block search, split and merge
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  input  dp_sts_t sts,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_UNITS;
      end
      S_UNITS: state_nxt = S_ORDER;
      S_ORDER: begin
        if (sts.ord_done) begin
          case (sts.op) inside
            OP_ALLOC, OP_PROBE: state_nxt = sts.ord_over ? S_DONE : S_SRCH_RD;
            OP_FREE: state_nxt = (sts.ord_over || sts.free_bad) ? S_DONE : S_MERGE_RD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH_RD: state_nxt = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (sts.mark) begin
          state_nxt = (sts.op == OP_ALLOC) ? S_SPLIT : S_DONE;
        end else if (sts.blk_last && sts.cur_top) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_SPLIT: begin
        if (sts.at_req) state_nxt = S_DONE;
      end
      S_MERGE_RD: state_nxt = sts.cur_top ? S_DONE : S_MERGE_CHK;
      S_MERGE_CHK: state_nxt = sts.mark ? S_MERGE_RD : S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd             = '0;
    cmd.status_code = STS_OK;
    busy            = 1'b1;
    out_valid       = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_UNITS: cmd.units_calc = 1'b1;
      S_ORDER: begin
        if (!sts.ord_done) begin
          cmd.ord_step = 1'b1;
        end else begin
          case (sts.op)
            OP_ALLOC: begin
              if (sts.ord_over) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = STS_TOO_LARGE;
              end else begin
                cmd.srch_start = 1'b1;
              end
            end
            OP_PROBE: cmd.srch_start = !sts.ord_over;
            OP_FREE:  cmd.free_start = !sts.ord_over && !sts.free_bad;
            default: ;
          endcase
        end
      end
      S_SRCH_RD: cmd.rd_cur = 1'b1;
      S_SRCH_CHK: begin
        if (sts.mark) begin
          if (sts.op == OP_ALLOC) cmd.wr_cur0 = 1'b1;
          else                    cmd.set_fits = 1'b1;
        end else if (sts.blk_last) begin
          if (sts.cur_top) begin
            if (sts.op == OP_ALLOC) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STS_NO_SPACE;
            end
          end else begin
            cmd.ord_next = 1'b1;
          end
        end else begin
          cmd.blk_next = 1'b1;
        end
      end
      S_SPLIT: begin
        if (sts.at_req) cmd.set_off = 1'b1;
        else            cmd.split_step = 1'b1;
      end
      S_MERGE_RD: begin
        if (sts.cur_top) cmd.wr_cur1 = 1'b1;
        else             cmd.rd_buddy = 1'b1;
      end
      S_MERGE_CHK: begin
        if (sts.mark) cmd.merge_step = 1'b1;
        else          cmd.wr_cur1 = 1'b1;
      end
      S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: rtl/bba_dpath.sv
// ----------------------------------------------------------------------------
// bba_dpath
// configuration, size to order conversion, block walk and free mark store
// ----------------------------------------------------------------------------
module bba_dpath import bba_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LOG2_W-1:0]    cfg_wdata,
  input  cmd_t                 cmd,
  output dp_sts_t              sts,
  output out_item_t            out_item
);

  localparam int AW      = MAX_ORDER + 1;
  localparam int OW      = $clog2(MAX_ORDER + 2);
  localparam int NODES   = (1 << (MAX_ORDER + 1)) - 1;
  localparam int BYTES_W = 33;
  localparam int UNITS_W = 34;
  localparam int SH_W    = 6;

  logic [LOG2_W-1:0]    unit_log2_r;
  logic [LOG2_W-1:0]    align_log2_r;
  opcode_t              op_r;
  logic [SIZE_W-1:0]    foff_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic [UNITS_W-1:0]   units_r;
  logic [OW-1:0]        ord_r;
  logic [OW-1:0]        cur_o_r;
  logic [MAX_ORDER-1:0] blk_r;
  logic [AW-1:0]        clr_cnt_r;
  out_item_t            out_r;

  logic [BYTES_W-1:0]   amask;
  logic [BYTES_W-1:0]   aligned;
  logic [UNITS_W-1:0]   unit_m1;
  logic [UNITS_W-1:0]   units_calc;
  logic [UNITS_W-1:0]   pow;
  logic                 ord_over;
  logic [SH_W-1:0]      k_sh;
  logic [SH_W-1:0]      top_sh;
  logic [SIZE_W-1:0]    low_mask;
  logic [MAX_ORDER-1:0] blk_free;
  logic [MAX_ORDER-1:0] blk_bud;
  logic [MAX_ORDER-1:0] blk_split;
  logic [AW-1:0]        last_blk;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic                 wdata;
  logic                 rdata;

  // node index of block b of order o, heap ordered with the root at zero
  function automatic logic [AW-1:0] node_of(logic [OW-1:0] o, logic [MAX_ORDER-1:0] b);
    logic [AW-1:0] base;
    base = (AW'(1) << (OW'(MAX_ORDER) - o)) - AW'(1);
    return base + AW'(b);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_log2_r  <= MIN_UNIT_RST;
      align_log2_r <= ALIGN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_UNIT: unit_log2_r  <= cfg_wdata;
        CFG_ALIGN:    align_log2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // size rounding and order search
  assign amask      = (BYTES_W'(1) << align_log2_r) - BYTES_W'(1);
  assign aligned    = (BYTES_W'(in_item.size_bytes) + amask) & ~amask;
  assign unit_m1    = (UNITS_W'(1) << unit_log2_r) - UNITS_W'(1);
  assign units_calc = (UNITS_W'(bytes_r) + unit_m1) >> unit_log2_r;
  assign pow        = UNITS_W'(1) << ord_r;
  assign ord_over   = ord_r > OW'(MAX_ORDER);

  // free item checks: alignment to the block size and range of the region
  assign k_sh     = SH_W'(ord_r) + SH_W'(unit_log2_r);
  assign top_sh   = SH_W'(unit_log2_r) + SH_W'(MAX_ORDER);
  assign low_mask = (k_sh >= SH_W'(SIZE_W)) ? '1 : ((SIZE_W'(1) << k_sh) - SIZE_W'(1));
  assign blk_free = MAX_ORDER'(foff_r >> k_sh);

  // block walk addresses
  assign blk_bud   = blk_r ^ MAX_ORDER'(1);
  assign blk_split = MAX_ORDER'({blk_r, 1'b1});
  assign last_blk  = (AW'(1) << (OW'(MAX_ORDER) - cur_o_r)) - AW'(1);
  assign raddr     = cmd.rd_buddy ? node_of(cur_o_r, blk_bud) : node_of(cur_o_r, blk_r);

  // single write port selection
  always_comb begin
    we    = 1'b1;
    waddr = node_of(cur_o_r, blk_r);
    wdata = 1'b0;
    if (cmd.clr_wr) begin
      waddr = clr_cnt_r;
      wdata = (clr_cnt_r == '0);
    end else if (cmd.wr_cur0) begin
      wdata = 1'b0;
    end else if (cmd.split_step) begin
      waddr = node_of(cur_o_r - OW'(1), blk_split);
      wdata = 1'b1;
    end else if (cmd.merge_step) begin
      waddr = node_of(cur_o_r, blk_bud);
    end else if (cmd.wr_cur1) begin
      wdata = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  bba_ram #(
    .WIDTH (1),
    .DEPTH (NODES)
  ) u_marks (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // transaction operands and walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.opcode;
      foff_r  <= in_item.free_offset_bytes;
      bytes_r <= (in_item.opcode == OP_FREE) ? BYTES_W'(in_item.size_bytes) : aligned;
      ord_r   <= '0;
    end else if (cmd.ord_step) begin
      ord_r <= ord_r + OW'(1);
    end
    if (cmd.units_calc) units_r <= units_calc;
    if (cmd.srch_start) begin
      cur_o_r <= ord_r;
      blk_r   <= '0;
    end else if (cmd.free_start) begin
      cur_o_r <= ord_r;
      blk_r   <= blk_free;
    end else if (cmd.blk_next) begin
      blk_r <= blk_r + MAX_ORDER'(1);
    end else if (cmd.ord_next) begin
      cur_o_r <= cur_o_r + OW'(1);
      blk_r   <= '0;
    end else if (cmd.split_step) begin
      cur_o_r <= cur_o_r - OW'(1);
      blk_r   <= blk_r << 1;
    end else if (cmd.merge_step) begin
      cur_o_r <= cur_o_r + OW'(1);
      blk_r   <= blk_r >> 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r <= '0;
    end else begin
      if (cmd.set_status) out_r.status <= cmd.status_code;
      if (cmd.set_fits)   out_r.fits   <= 1'b1;
      if (cmd.set_off) begin
        out_r.alloc_offset_bytes <= (SIZE_W'(blk_r) << cur_o_r) << unit_log2_r;
      end
    end
  end

  assign out_item = out_r;

  // status towards the controller
  always_comb begin
    sts          = '0;
    sts.clr_last = (clr_cnt_r == AW'(NODES - 1));
    sts.op       = op_r;
    sts.ord_done = !((pow < units_r) && !ord_over);
    sts.ord_over = ord_over;
    sts.free_bad = (|(foff_r & low_mask)) || (|(foff_r >> top_sh));
    sts.mark     = rdata;
    sts.blk_last = (AW'(blk_r) == last_blk);
    sts.cur_top  = (cur_o_r == OW'(MAX_ORDER));
    sts.at_req   = (cur_o_r == ord_r);
  end

endmodule

// File: rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// port level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // a result only appears while a transaction is in flight
  a_out_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a transaction");

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction not busy");

  // one result per transaction, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("repeated result strobe");

  // failed allocations carry a zero offset
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STS_OK) |-> (out_item.alloc_offset_bytes == '0))
    else $error("offset on failed allocation");

  // a probe answer comes with ok status and no offset
  a_fits_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.fits) |->
      (out_item.status == STS_OK && out_item.alloc_offset_bytes == '0))
    else $error("probe answer with other fields set");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the buddy block allocator core: a scoreboard keeps
// its own copy of the free-mark tree and settings, predicts every result and
// compares it with the block; stimulus mixes directed cases, well-formed
// allocate/free traffic and raw noise over several unit and alignment settings
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int MAXO       = MAX_ORDER_DEF;
  localparam int MARKS      = (1 << (MAXO + 1)) - 1;
  localparam int CYCLE_CAP  = 3000000;
  localparam int PHASE_ITEMS = 62;

  // allocator mirror and expected-result store
  class alloc_scoreboard;
    bit                        marks [MARKS];
    int unsigned               unit_log2;
    int unsigned               align_log2;
    out_item_t                 expected_q [$];
    logic [SIZE_W-1:0]         live_off [$];
    logic [SIZE_W-1:0]         live_len [$];
    int unsigned               errors;

    function new();
      foreach (marks[i]) marks[i] = 1'b0;
      marks[0]   = 1'b1;
      unit_log2  = MIN_UNIT_RST;
      align_log2 = ALIGN_RST;
      errors     = 0;
    endfunction

    function int unsigned node(int unsigned ord, int unsigned blk);
      return (1 << (MAXO - ord)) - 1 + blk;
    endfunction

    // order needed for a byte count, above MAXO when too large
    function int unsigned order_for(longint unsigned bytes);
      longint unsigned unit_b, units;
      int unsigned o;
      unit_b = 64'd1 << unit_log2;
      units  = (bytes + unit_b - 1) >> unit_log2;
      o = 0;
      while ((64'd1 << o) < units && o <= MAXO) o++;
      return o;
    endfunction

    function int first_free(int unsigned ord);
      for (int unsigned b = 0; b < (1 << (MAXO - ord)); b++)
        if (marks[node(ord, b)]) return b;
      return -1;
    endfunction

    // note an accepted transaction and queue its expected result
    function void note_item(in_item_t it);
      out_item_t       r;
      longint unsigned amask, aligned, off, blen, units;
      int unsigned     ord, o, b;
      int              blk;
      r = '0;
      amask   = (64'd1 << align_log2) - 1;
      aligned = (64'(it.size_bytes) + amask) & ~amask;
      case (it.opcode)
        OP_ALLOC: begin
          ord = order_for(aligned);
          blk = -1;
          if (ord > MAXO) begin
            r.status = STS_TOO_LARGE;
          end else begin
            for (o = ord; o <= MAXO; o++) begin
              blk = first_free(o);
              if (blk >= 0) break;
            end
            if (blk < 0) begin
              r.status = STS_NO_SPACE;
            end else begin
              b = blk;
              marks[node(o, b)] = 1'b0;
              // split down, right halves stay free
              while (o > ord) begin
                o--;
                b = b << 1;
                marks[node(o, b + 1)] = 1'b1;
              end
              off  = (64'(b) << ord) << unit_log2;
              blen = 64'd1 << (ord + unit_log2);
              r.alloc_offset_bytes = off[SIZE_W-1:0];
              live_off.push_back(off[SIZE_W-1:0]);
              live_len.push_back(blen > 64'hFFFFFF ? 24'hFFFFFF : blen[SIZE_W-1:0]);
            end
          end
        end
        OP_FREE: begin
          ord   = order_for(64'(it.size_bytes));
          units = 64'(it.free_offset_bytes) >> unit_log2;
          if (ord <= MAXO &&
              (64'(it.free_offset_bytes) & ((64'd1 << (ord + unit_log2)) - 1)) == 0 &&
              units < (64'd1 << MAXO)) begin
            b = units >> ord;
            // merge with free buddies upward
            while (ord < MAXO && marks[node(ord, b ^ 1)]) begin
              marks[node(ord, b ^ 1)] = 1'b0;
              ord++;
              b = b >> 1;
            end
            marks[node(ord, b)] = 1'b1;
          end
        end
        OP_PROBE: begin
          ord = order_for(aligned);
          for (o = ord; o <= MAXO; o++)
            if (first_free(o) >= 0) begin
              r.fits = 1'b1;
              break;
            end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.alloc_offset_bytes !== want.alloc_offset_bytes ||
          got.fits !== want.fits) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status %0d/%0d offset %h/%h fits %b/%b (exp/act)",
                   want.status, got.status, want.alloc_offset_bytes,
                   got.alloc_offset_bytes, want.fits, got.fits);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LOG2_W-1:0]    cfg_wdata;

  alloc_scoreboard sb;
  int unsigned     cycles;
  bit              idle_on;

  buddy_block_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result monitor and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_item);
    if (cycles > CYCLE_CAP) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // random pause on the input side, start held low
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // present one transaction and return at the edge that takes it
  task automatic send_item(in_item_t it);
    maybe_idle();
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic send_op(opcode_t op, logic [SIZE_W-1:0] sz, logic [SIZE_W-1:0] off);
    in_item_t it;
    it.opcode            = op;
    it.size_bytes        = sz;
    it.free_offset_bytes = off;
    send_item(it);
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LOG2_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MIN_UNIT) sb.unit_log2 = val;
    else sb.align_log2 = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    longint unsigned cap;
    case ($urandom_range(0, 7))
      0: return SIZE_W'($urandom);
      1: return '0;
      default: begin
        cap = 64'd1 << (sb.unit_log2 + $urandom_range(0, 9));
        if (cap > 64'hFFFFFF) cap = 64'hFFFFFF;
        return SIZE_W'($urandom_range(1, int'(cap)));
      end
    endcase
  endfunction

  // return one live block, chosen at random
  task automatic free_live();
    int unsigned k;
    logic [SIZE_W-1:0] o, l;
    k = $urandom_range(0, sb.live_off.size() - 1);
    o = sb.live_off[k];
    l = sb.live_len[k];
    sb.live_off.delete(k);
    sb.live_len.delete(k);
    send_op(OP_FREE, l, o);
  endtask

  task automatic random_phase();
    in_item_t it;
    int unsigned pick;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && sb.live_off.size() != 0) begin
        free_live();
      end else if (pick < 80) begin
        send_op(OP_ALLOC, pick_size(), '0);
      end else if (pick < 90) begin
        send_op(OP_PROBE, pick_size(), SIZE_W'($urandom));
      end else begin
        it = in_item_t'({$urandom, $urandom});
        send_item(it);
      end
    end
    // give everything back so the next setting starts from an empty region
    while (sb.live_off.size() != 0) free_live();
  endtask

  initial begin
    logic [LOG2_W-1:0] unit_set  [6];
    logic [LOG2_W-1:0] align_set [6];
    unit_set  = '{5'd0, 5'd16, 5'd4, 5'd31, 5'd12, 5'd2};
    align_set = '{5'd0, 5'd16, 5'd10, 5'd31, 5'd3, 5'd20};
    sb        = new();
    cycles    = 0;
    idle_on   = 1'b1;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: whole region, exhaustion, oversize, bad frees, double free
    send_op(OP_ALLOC, 24'd0, '0);
    send_op(OP_FREE, 24'd1, 24'd0);
    send_op(OP_ALLOC, 24'd65536, '0);
    send_op(OP_ALLOC, 24'd1, '0);
    send_op(OP_PROBE, 24'd1, '0);
    send_op(OP_FREE, 24'd65536, 24'd0);
    send_op(OP_PROBE, 24'd65536, 24'hFFFFFF);
    send_op(OP_PROBE, 24'hFFFFFF, '0);
    send_op(OP_ALLOC, 24'hFFFFFF, '0);
    send_op(OP_ALLOC, 24'd65537, '0);
    send_op(OP_ALLOC, 24'd257, '0);
    send_op(OP_ALLOC, 24'd1, '0);
    send_op(OP_FREE, 24'd256, 24'd384);
    send_op(OP_FREE, 24'd512, 24'd65536);
    send_op(OP_FREE, 24'hFFFFFF, 24'd0);
    send_op(OP_FREE, 24'd256, 24'd1024);
    send_op(OP_FREE, 24'd256, 24'd1024);
    send_op(OP_NONE, 24'hFFFFFF, 24'hFFFFFF);
    send_op(OP_FREE, 24'd512, 24'd0);
    send_op(OP_FREE, 24'd256, 24'd512);
    send_op(OP_PROBE, 24'd65536, '0);
    random_phase();

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(CFG_MIN_UNIT, unit_set[p]);
      write_reg(CFG_ALIGN, align_set[p]);
      idle_on = (p != 2);
      random_phase();
    end

    drain();
    repeat (1200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule
